// File: design/tfg_pkg.sv
// ----------------------------------------------------------------------------
// tfg_pkg
// Shared types and constants for the TFT window fill and glyph sequencer.
// ----------------------------------------------------------------------------
package tfg_pkg;

	// Request selector codes. Code three is not a start and acts as a tick.
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_FILL  = 2'd1;
	localparam logic [1:0] CMD_GLYPH = 2'd2;

	// Classified item kinds as seen by the back end.
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_FILL  = 2'd1;
	localparam logic [1:0] KIND_GLYPH = 2'd2;

	// Display controller opcodes.
	localparam logic [7:0] OP_COLSET = 8'h2A;
	localparam logic [7:0] OP_ROWSET = 8'h2B;
	localparam logic [7:0] OP_MEMWR  = 8'h2C;
	localparam logic [7:0] BYTE_ZERO = 8'h00;

	// Byte sequence steps.
	localparam logic [3:0] STEP_COLSET = 4'd0;
	localparam logic [3:0] STEP_X0     = 4'd2;
	localparam logic [3:0] STEP_X1     = 4'd4;
	localparam logic [3:0] STEP_ROWSET = 4'd5;
	localparam logic [3:0] STEP_Y0     = 4'd7;
	localparam logic [3:0] STEP_Y1     = 4'd9;
	localparam logic [3:0] STEP_MEMWR  = 4'd10;
	localparam logic [3:0] STEP_HI     = 4'd11;
	localparam logic [3:0] STEP_LO     = 4'd12;

	// Glyph column inputs per request and column slots in the store.
	localparam int GLYPH_INPUTS = 5;
	localparam int GLYPH_SLOTS  = 8;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  pos_x;
		logic [7:0]  pos_y;
		logic [7:0]  rect_w;
		logic [7:0]  rect_h;
		logic [15:0] fg_color;
		logic [15:0] bg_color;
		logic [7:0]  glyph_col0;
		logic [7:0]  glyph_col1;
		logic [7:0]  glyph_col2;
		logic [7:0]  glyph_col3;
		logic [7:0]  glyph_col4;
	} req_t;

	typedef struct packed {
		logic        byte_valid;
		logic [7:0]  out_byte;
		logic        is_data;
		logic        last_byte;
		logic        busy_res;
		logic        rejected;
	} rsp_t;

	typedef struct packed {
		logic [1:0]                        kind;
		logic [7:0]                        pos_x;
		logic [7:0]                        pos_y;
		logic [7:0]                        rect_w;
		logic [7:0]                        rect_h;
		logic [15:0]                       fg_color;
		logic [15:0]                       bg_color;
		logic [GLYPH_INPUTS-1:0][7:0]      glyph;
		logic [15:0]                       area;
	} item_t;

endpackage

// File: design/tfg_front.sv
// ----------------------------------------------------------------------------
// tfg_front
// Accepts requests, classifies them and precomputes the fill pixel count.
// ----------------------------------------------------------------------------
module tfg_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  tfg_pkg::req_t req,
	output logic          push,
	output tfg_pkg::item_t push_item,
	input  logic          full
);

	logic           valid_s1;
	tfg_pkg::item_t item_s1;
	tfg_pkg::item_t item_d;

	// The stage holds only when the queue cannot take its item.
	assign push      = valid_s1 && !full;
	assign req_stall = valid_s1 && full;
	assign push_item = item_s1;

	// Classify the selector and gather the glyph columns.
	always_comb begin
		item_d.pos_x    = req.pos_x;
		item_d.pos_y    = req.pos_y;
		item_d.rect_w   = req.rect_w;
		item_d.rect_h   = req.rect_h;
		item_d.fg_color = req.fg_color;
		item_d.bg_color = req.bg_color;
		item_d.glyph[0] = req.glyph_col0;
		item_d.glyph[1] = req.glyph_col1;
		item_d.glyph[2] = req.glyph_col2;
		item_d.glyph[3] = req.glyph_col3;
		item_d.glyph[4] = req.glyph_col4;
		item_d.area     = 16'(req.rect_w) * 16'(req.rect_h);
		unique case (req.cmd)
			tfg_pkg::CMD_FILL:  item_d.kind = tfg_pkg::KIND_FILL;
			tfg_pkg::CMD_GLYPH: item_d.kind = tfg_pkg::KIND_GLYPH;
			default:            item_d.kind = tfg_pkg::KIND_TICK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	// Payload loads on every accepted transfer.
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= item_d;
		end
	end

endmodule

// File: design/tfg_queue.sv
// ----------------------------------------------------------------------------
// tfg_queue
// Small first-in first-out queue between the front and the back end.
// ----------------------------------------------------------------------------
module tfg_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tfg_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           pop_valid,
	output tfg_pkg::item_t pop_item
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	tfg_pkg::item_t    mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = count_q == CNT_W'(DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_item  = mem_q[rd_ptr_q];

	// Pointers wrap explicitly so any depth works.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

`ifndef SYNTH
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");
`endif

endmodule

// File: design/tfg_back.sv
// ----------------------------------------------------------------------------
// tfg_back
// Carries out queued items: holds the request state and emits one result
// per item into an output register.
// ----------------------------------------------------------------------------
module tfg_back #(
	parameter int GLYPH_COLUMNS = 5,
	parameter int GLYPH_ROWS    = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  tfg_pkg::item_t q_item,
	output logic           pop,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output tfg_pkg::rsp_t  rsp
);

	// Request state.
	logic        active_q;
	logic        glyph_mode_q;
	logic [7:0]  win_x_q;
	logic [7:0]  win_y_q;
	logic [7:0]  win_w_q;
	logic [7:0]  win_h_q;
	logic [15:0] fore_q;
	logic [15:0] back_q;
	logic [3:0]  step_q;
	logic [15:0] pixels_q;
	logic [2:0]  column_q;
	logic [2:0]  row_q;
	logic [7:0]  glyph_q [tfg_pkg::GLYPH_SLOTS];

	logic        n_active;
	logic [3:0]  n_step;
	logic [15:0] n_pixels;
	logic [2:0]  n_column;
	logic [2:0]  n_row;
	logic        load;

	logic          rsp_valid_q;
	tfg_pkg::rsp_t rsp_q;
	tfg_pkg::rsp_t rsp_d;

	logic [7:0]  x0;
	logic [7:0]  x1;
	logic [7:0]  y0;
	logic [7:0]  y1;
	logic [7:0]  win_byte;
	logic [15:0] pix_color;
	logic        start;
	logic        row_end;
	logic        col_end;

	assign start     = q_item.kind != tfg_pkg::KIND_TICK;
	assign pop       = q_valid && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign row_end = ({1'b0, row_q} + 4'd1) >= 4'(GLYPH_ROWS);
	assign col_end = ({1'b0, column_q} + 4'd1) >= 4'(GLYPH_COLUMNS);

	// Window corners: one pixel per glyph dot, or the whole fill rectangle.
	always_comb begin
		if (glyph_mode_q) begin
			x0 = win_x_q + {5'd0, column_q};
			x1 = x0;
			y0 = win_y_q + {5'd0, row_q};
			y1 = y0;
		end else begin
			x0 = win_x_q;
			x1 = win_x_q + win_w_q - 8'd1;
			y0 = win_y_q;
			y1 = win_y_q + win_h_q - 8'd1;
		end
	end

	always_comb begin
		unique case (step_q)
			tfg_pkg::STEP_COLSET: win_byte = tfg_pkg::OP_COLSET;
			tfg_pkg::STEP_X0:     win_byte = x0;
			tfg_pkg::STEP_X1:     win_byte = x1;
			tfg_pkg::STEP_ROWSET: win_byte = tfg_pkg::OP_ROWSET;
			tfg_pkg::STEP_Y0:     win_byte = y0;
			tfg_pkg::STEP_Y1:     win_byte = y1;
			tfg_pkg::STEP_MEMWR:  win_byte = tfg_pkg::OP_MEMWR;
			default:              win_byte = tfg_pkg::BYTE_ZERO;
		endcase
	end

	// A glyph dot picks foreground for a set bit, background otherwise.
	assign pix_color = (!glyph_mode_q || glyph_q[column_q][row_q]) ? fore_q : back_q;

	// Next state and the result for the item at the head of the queue.
	always_comb begin
		n_active = active_q;
		n_step   = step_q;
		n_pixels = pixels_q;
		n_column = column_q;
		n_row    = row_q;
		load     = 1'b0;
		rsp_d    = '0;
		if (start) begin
			if (active_q) begin
				rsp_d.rejected = 1'b1;
			end else begin
				load     = 1'b1;
				n_active = 1'b1;
				n_step   = tfg_pkg::STEP_COLSET;
				n_pixels = q_item.area;
				n_column = '0;
				n_row    = '0;
			end
			rsp_d.busy_res = 1'b1;
		end else if (active_q) begin
			rsp_d.byte_valid = 1'b1;
			if (step_q <= tfg_pkg::STEP_MEMWR) begin
				rsp_d.out_byte = win_byte;
				rsp_d.is_data  = !(step_q == tfg_pkg::STEP_COLSET ||
					step_q == tfg_pkg::STEP_ROWSET || step_q == tfg_pkg::STEP_MEMWR);
				if (step_q == tfg_pkg::STEP_MEMWR && !glyph_mode_q && pixels_q == '0) begin
					rsp_d.last_byte = 1'b1;
					n_active        = 1'b0;
					n_step          = tfg_pkg::STEP_COLSET;
				end else begin
					n_step = step_q + 4'd1;
				end
			end else if (step_q == tfg_pkg::STEP_HI) begin
				rsp_d.out_byte = pix_color[15:8];
				rsp_d.is_data  = 1'b1;
				n_step         = tfg_pkg::STEP_LO;
			end else begin
				rsp_d.out_byte = pix_color[7:0];
				rsp_d.is_data  = 1'b1;
				if (glyph_mode_q) begin
					n_step = tfg_pkg::STEP_COLSET;
					if (row_end) begin
						if (col_end) begin
							rsp_d.last_byte = 1'b1;
							n_active        = 1'b0;
						end else begin
							n_row    = '0;
							n_column = column_q + 3'd1;
						end
					end else begin
						n_row = row_q + 3'd1;
					end
				end else begin
					n_pixels = pixels_q - 16'd1;
					if (n_pixels == '0) begin
						rsp_d.last_byte = 1'b1;
						n_active        = 1'b0;
						n_step          = tfg_pkg::STEP_COLSET;
					end else begin
						n_step = tfg_pkg::STEP_HI;
					end
				end
			end
			rsp_d.busy_res = n_active;
		end
	end

	// Control state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			glyph_mode_q <= 1'b0;
			win_x_q      <= '0;
			win_y_q      <= '0;
			win_w_q      <= '0;
			win_h_q      <= '0;
			fore_q       <= '0;
			back_q       <= '0;
			step_q       <= tfg_pkg::STEP_COLSET;
			pixels_q     <= '0;
			column_q     <= '0;
			row_q        <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= n_active;
				step_q   <= n_step;
				pixels_q <= n_pixels;
				column_q <= n_column;
				row_q    <= n_row;
				if (load) begin
					glyph_mode_q <= q_item.kind == tfg_pkg::KIND_GLYPH;
					win_x_q      <= q_item.pos_x;
					win_y_q      <= q_item.pos_y;
					win_w_q      <= q_item.rect_w;
					win_h_q      <= q_item.rect_h;
					fore_q       <= q_item.fg_color;
					back_q       <= q_item.bg_color;
				end
			end
			if (pop) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Glyph columns and the result payload need no reset.
	always_ff @(posedge clk) begin
		if (pop && load && q_item.kind == tfg_pkg::KIND_GLYPH) begin
			for (int i = 0; i < tfg_pkg::GLYPH_INPUTS; i++) begin
				glyph_q[i] <= q_item.glyph[i];
			end
			for (int i = tfg_pkg::GLYPH_INPUTS; i < tfg_pkg::GLYPH_SLOTS; i++) begin
				glyph_q[i] <= '0;
			end
		end
		if (pop) begin
			rsp_q <= rsp_d;
		end
	end

`ifndef SYNTH
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.last_byte |-> !rsp_q.busy_res && rsp_q.byte_valid)
		else $error("last byte reported while still busy");
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.rejected |-> rsp_q.busy_res && !rsp_q.byte_valid)
		else $error("rejected result with a byte or while idle");
	a_idle_step: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> step_q == tfg_pkg::STEP_COLSET)
		else $error("sequence step left mid-way while idle");
`endif

endmodule

// File: design/tft_window_fill_glyph_sequencer_core.sv
// ----------------------------------------------------------------------------
// tft_window_fill_glyph_sequencer_core
// Turns fill and glyph requests plus byte-slot ticks into the command and
// data byte stream for a TFT controller, one result per request.
//
// Channel   Direction  Payload          Handshake
// req       in         tfg_pkg::req_t   req_valid / req_stall
// rsp       out        tfg_pkg::rsp_t   rsp_valid / rsp_stall
//
// Every request, tick or start, yields exactly one result, in order.
// A request is accepted each cycle unless req_stall holds it; its result is
// offered after it passes the front register, the queue and the output
// register.
// The back end retires one queued request per cycle unless a result stall holds it.
// Reset clears the request state and empties the queue.
// A result stall holds the output register; the queue then absorbs requests
// until it fills, and only then is req_stall raised.
// ----------------------------------------------------------------------------
module tft_window_fill_glyph_sequencer_core #(
	parameter int GLYPH_COLUMNS = 5,
	parameter int GLYPH_ROWS    = 8,
	parameter int QUEUE_DEPTH   = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  tfg_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output tfg_pkg::rsp_t rsp
);

	logic           push;
	logic           full;
	logic           pop;
	logic           q_valid;
	tfg_pkg::item_t push_item;
	tfg_pkg::item_t q_item;

	tfg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.push      (push),
		.push_item (push_item),
		.full      (full)
	);

	tfg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_valid (q_valid),
		.pop_item  (q_item)
	);

	tfg_back #(
		.GLYPH_COLUMNS (GLYPH_COLUMNS),
		.GLYPH_ROWS    (GLYPH_ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// File: verif/tft_window_fill_glyph_sequencer_core_tb.sv
// ----------------------------------------------------------------------------
// tft_window_fill_glyph_sequencer_core_tb
// Self-checking bench for the TFT window fill and glyph byte sequencer.
// Requests and byte-slot ticks are pushed through the request channel while
// a behavioral copy of the sequencer predicts the byte, flags and status of
// every transfer. Results are compared field by field in order. Directed
// cases come first, then random fills and glyphs under several idle mixes,
// with one long result hold-off that fills the block's internal queue.
// ----------------------------------------------------------------------------
module tft_window_fill_glyph_sequencer_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 12;
	localparam int GLYPH_COLUMNS  = 5;
	localparam int GLYPH_ROWS     = 8;
	localparam int WINDOW_BYTES   = 11;
	localparam int PIXEL_BYTES    = 2;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PRINT_LIMIT    = 200;
	localparam int PHASE_ITEMS    = 150;

	// Selector code three is not a start and behaves as a tick.
	localparam logic [1:0] CMD_SPARE = 2'd3;

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_stall;
	tfg_pkg::req_t  req       = '0;
	logic           rsp_valid;
	logic           rsp_stall = 1'b0;
	tfg_pkg::rsp_t  rsp;

	// Idle mix and hold-off control shared with the driving processes.
	int    send_idle_pct  = 0;
	int    recv_stall_pct = 0;
	logic  hold_go        = 1'b0;
	int    hold_left      = 0;

	int    items_sent     = 0;
	int    mismatch_count = 0;
	int    quiet_cycles   = 0;

	// Expected results, oldest first.
	tfg_pkg::rsp_t  due_slots[$];

	// Behavioral copy of the sequencer state.
	logic        seq_busy   = 1'b0;
	logic        glyph_draw = 1'b0;
	logic [7:0]  win_x      = '0;
	logic [7:0]  win_y      = '0;
	logic [7:0]  win_w      = '0;
	logic [7:0]  win_h      = '0;
	logic [15:0] fore_rgb   = '0;
	logic [15:0] back_rgb   = '0;
	logic [7:0]  col_bits [tfg_pkg::GLYPH_SLOTS];
	logic [3:0]  seq_pos    = tfg_pkg::STEP_COLSET;
	logic [15:0] px_left    = '0;
	logic [2:0]  gcol       = '0;
	logic [2:0]  grow       = '0;

	tft_window_fill_glyph_sequencer_core #(
		.GLYPH_COLUMNS(GLYPH_COLUMNS),
		.GLYPH_ROWS   (GLYPH_ROWS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Advances the sequencer copy by one accepted request and returns the
	// result that request produces.
	task automatic advance_sequencer(input tfg_pkg::req_t r, output tfg_pkg::rsp_t o);
		logic [7:0]  x0;
		logic [7:0]  x1;
		logic [7:0]  y0;
		logic [7:0]  y1;
		logic [15:0] color;
		int          k;
		o = '0;
		if (r.cmd == tfg_pkg::CMD_FILL || r.cmd == tfg_pkg::CMD_GLYPH) begin
			if (seq_busy) begin
				o.rejected = 1'b1;
			end else begin
				seq_busy   = 1'b1;
				glyph_draw = (r.cmd == tfg_pkg::CMD_GLYPH);
				win_x      = r.pos_x;
				win_y      = r.pos_y;
				win_w      = r.rect_w;
				win_h      = r.rect_h;
				fore_rgb   = r.fg_color;
				back_rgb   = r.bg_color;
				if (glyph_draw) begin
					for (k = 0; k < tfg_pkg::GLYPH_SLOTS; k++)
						col_bits[k] = tfg_pkg::BYTE_ZERO;
					col_bits[0] = r.glyph_col0;
					col_bits[1] = r.glyph_col1;
					col_bits[2] = r.glyph_col2;
					col_bits[3] = r.glyph_col3;
					col_bits[4] = r.glyph_col4;
				end
				seq_pos = tfg_pkg::STEP_COLSET;
				px_left = 16'(win_w) * 16'(win_h);
				gcol    = '0;
				grow    = '0;
			end
		end else if (seq_busy) begin
			o.byte_valid = 1'b1;
			// A glyph pixel gets a one-pixel window; a fill spans the rectangle.
			if (glyph_draw) begin
				x0 = win_x + 8'(gcol);
				x1 = x0;
				y0 = win_y + 8'(grow);
				y1 = y0;
				color = col_bits[gcol][grow] ? fore_rgb : back_rgb;
			end else begin
				x0 = win_x;
				x1 = win_x + win_w - 8'd1;
				y0 = win_y;
				y1 = win_y + win_h - 8'd1;
				color = fore_rgb;
			end
			if (seq_pos <= tfg_pkg::STEP_MEMWR) begin
				case (seq_pos)
					tfg_pkg::STEP_COLSET: o.out_byte = tfg_pkg::OP_COLSET;
					tfg_pkg::STEP_X0:     o.out_byte = x0;
					tfg_pkg::STEP_X1:     o.out_byte = x1;
					tfg_pkg::STEP_ROWSET: o.out_byte = tfg_pkg::OP_ROWSET;
					tfg_pkg::STEP_Y0:     o.out_byte = y0;
					tfg_pkg::STEP_Y1:     o.out_byte = y1;
					tfg_pkg::STEP_MEMWR:  o.out_byte = tfg_pkg::OP_MEMWR;
					default:              o.out_byte = tfg_pkg::BYTE_ZERO;
				endcase
				o.is_data = !(seq_pos == tfg_pkg::STEP_COLSET ||
					seq_pos == tfg_pkg::STEP_ROWSET || seq_pos == tfg_pkg::STEP_MEMWR);
				// An empty fill ends on the memory write opcode.
				if (seq_pos == tfg_pkg::STEP_MEMWR && !glyph_draw && px_left == '0) begin
					o.last_byte = 1'b1;
					seq_busy    = 1'b0;
					seq_pos     = tfg_pkg::STEP_COLSET;
				end else begin
					seq_pos = seq_pos + 4'd1;
				end
			end else if (seq_pos == tfg_pkg::STEP_HI) begin
				o.out_byte = color[15:8];
				o.is_data  = 1'b1;
				seq_pos    = tfg_pkg::STEP_LO;
			end else begin
				o.out_byte = color[7:0];
				o.is_data  = 1'b1;
				if (glyph_draw) begin
					if (int'(grow) + 1 >= GLYPH_ROWS) begin
						if (int'(gcol) + 1 >= GLYPH_COLUMNS) begin
							o.last_byte = 1'b1;
							seq_busy    = 1'b0;
						end else begin
							grow = '0;
							gcol = gcol + 3'd1;
						end
					end else begin
						grow = grow + 3'd1;
					end
					seq_pos = tfg_pkg::STEP_COLSET;
				end else begin
					px_left = px_left - 16'd1;
					if (px_left == '0) begin
						o.last_byte = 1'b1;
						seq_busy    = 1'b0;
						seq_pos     = tfg_pkg::STEP_COLSET;
					end else begin
						seq_pos = tfg_pkg::STEP_HI;
					end
				end
			end
		end
		o.busy_res = seq_busy;
	endtask

	task automatic report_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] exp_val);
		if (mismatch_count < PRINT_LIMIT)
			$display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what,
				got, exp_val);
		mismatch_count++;
	endtask

	// Predicts on every request transfer and checks every result transfer.
	always @(posedge clk) begin
		tfg_pkg::rsp_t want;
		logic moved;
		moved = 1'b0;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				advance_sequencer(req, want);
				due_slots.push_back(want);
				moved = 1'b1;
			end
			if (rsp_valid && !rsp_stall) begin
				moved = 1'b1;
				if (due_slots.size() == 0) begin
					report_mismatch("result with nothing expected", rsp.out_byte, '0);
				end else begin
					want = due_slots.pop_front();
					if (rsp.byte_valid !== want.byte_valid)
						report_mismatch("byte_valid", rsp.byte_valid, want.byte_valid);
					if (rsp.out_byte !== want.out_byte)
						report_mismatch("out_byte", rsp.out_byte, want.out_byte);
					if (rsp.is_data !== want.is_data)
						report_mismatch("is_data", rsp.is_data, want.is_data);
					if (rsp.last_byte !== want.last_byte)
						report_mismatch("last_byte", rsp.last_byte, want.last_byte);
					if (rsp.busy_res !== want.busy_res)
						report_mismatch("busy_res", rsp.busy_res, want.busy_res);
					if (rsp.rejected !== want.rejected)
						report_mismatch("rejected", rsp.rejected, want.rejected);
				end
			end
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
	end

	// Result side: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_go) begin
			hold_left = HOLD_CYCLES;
			hold_go <= 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Ends the run when no transfer happens for too long.
	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	// Offers one request and returns once it has been transferred.
	task automatic send_item(input tfg_pkg::req_t item);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do
			@(posedge clk);
		while (req_stall);
		items_sent++;
	endtask

	function automatic tfg_pkg::req_t random_req(input logic [1:0] code);
		tfg_pkg::req_t r;
		r.cmd        = code;
		r.pos_x      = 8'($urandom);
		r.pos_y      = 8'($urandom);
		r.rect_w     = 8'($urandom);
		r.rect_h     = 8'($urandom);
		r.fg_color   = 16'($urandom);
		r.bg_color   = 16'($urandom);
		r.glyph_col0 = 8'($urandom);
		r.glyph_col1 = 8'($urandom);
		r.glyph_col2 = 8'($urandom);
		r.glyph_col3 = 8'($urandom);
		r.glyph_col4 = 8'($urandom);
		return r;
	endfunction

	function automatic tfg_pkg::req_t random_tick();
		return random_req(($urandom_range(0, 3) == 0) ? CMD_SPARE : tfg_pkg::CMD_TICK);
	endfunction

	// Sends a start and exactly enough ticks to finish it; noise_pct mixes in
	// start requests that arrive while busy and must be turned away.
	task automatic run_request(input tfg_pkg::req_t start, input int noise_pct);
		int slots;
		if (start.cmd == tfg_pkg::CMD_GLYPH)
			slots = GLYPH_COLUMNS * GLYPH_ROWS * (WINDOW_BYTES + PIXEL_BYTES);
		else
			slots = WINDOW_BYTES + PIXEL_BYTES * int'(start.rect_w) * int'(start.rect_h);
		send_item(start);
		while (slots > 0) begin
			if ($urandom_range(0, 99) < noise_pct) begin
				send_item(random_req($urandom_range(0, 1) ? tfg_pkg::CMD_FILL :
					tfg_pkg::CMD_GLYPH));
			end else begin
				send_item(random_tick());
				slots--;
			end
		end
	endtask

	// Fill sizes stay small except where one side is zero.
	function automatic tfg_pkg::req_t random_fill();
		tfg_pkg::req_t r;
		int   pick;
		r    = random_req(tfg_pkg::CMD_FILL);
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			r.rect_w = 8'($urandom_range(0, 3));
			r.rect_h = 8'($urandom_range(0, 3));
		end else if (pick < 85) begin
			if ($urandom_range(0, 1))
				r.rect_h = '0;
			else
				r.rect_w = '0;
		end else begin
			r.rect_w = 8'($urandom_range(1, 8));
			r.rect_h = 8'($urandom_range(1, 8));
		end
		return r;
	endfunction

	// Ticks of both kinds while nothing is in progress.
	task automatic test_idle_ticks();
		tfg_pkg::req_t r;
		r     = '0;
		send_item(r);
		r     = '1;
		r.cmd = CMD_SPARE;
		send_item(r);
	endtask

	// Fills with a zero side send only the window bytes, with wrapped ends.
	task automatic test_empty_fills();
		tfg_pkg::req_t f;
		f          = '0;
		f.cmd      = tfg_pkg::CMD_FILL;
		f.rect_w   = 8'hFF;
		f.fg_color = 16'hFFFF;
		run_request(f, 0);
		f          = '0;
		f.cmd      = tfg_pkg::CMD_FILL;
		f.pos_x    = 8'hFF;
		f.pos_y    = 8'hFF;
		f.rect_h   = 8'hFF;
		f.bg_color = 16'hFFFF;
		run_request(f, 0);
		f          = '0;
		f.cmd      = tfg_pkg::CMD_FILL;
		run_request(f, 0);
	endtask

	// Small rectangles, including a single pixel at the far corner.
	task automatic test_small_fills();
		tfg_pkg::req_t f;
		f          = '0;
		f.cmd      = tfg_pkg::CMD_FILL;
		f.pos_x    = 8'hFF;
		f.pos_y    = 8'hFF;
		f.rect_w   = 8'd1;
		f.rect_h   = 8'd1;
		f.fg_color = 16'hFFFF;
		run_request(f, 0);
		f          = '0;
		f.cmd      = tfg_pkg::CMD_FILL;
		f.rect_w   = 8'd2;
		f.rect_h   = 8'd3;
		run_request(f, 0);
		f          = random_req(tfg_pkg::CMD_FILL);
		f.rect_w   = 8'd3;
		f.rect_h   = 8'd2;
		run_request(f, 0);
	endtask

	// Starts of both kinds while busy are rejected and leave the fill intact.
	task automatic test_busy_rejects();
		tfg_pkg::req_t f;
		int   slots;
		f        = random_req(tfg_pkg::CMD_FILL);
		f.rect_w = 8'd1;
		f.rect_h = 8'd1;
		send_item(f);
		send_item(random_req(tfg_pkg::CMD_FILL));
		send_item(random_req(tfg_pkg::CMD_GLYPH));
		for (slots = WINDOW_BYTES + PIXEL_BYTES; slots > 0; slots--)
			send_item(random_tick());
	endtask

	// One glyph whose pixel coordinates wrap, with edge column patterns.
	task automatic test_glyph_draw();
		tfg_pkg::req_t g;
		g            = '0;
		g.cmd        = tfg_pkg::CMD_GLYPH;
		g.pos_x      = 8'd252;
		g.pos_y      = 8'd250;
		g.fg_color   = 16'hFFFF;
		g.glyph_col0 = 8'h01;
		g.glyph_col1 = 8'h80;
		g.glyph_col2 = 8'hFF;
		g.glyph_col3 = 8'h00;
		g.glyph_col4 = 8'hA5;
		run_request(g, 5);
	endtask

	// The result side holds off while requests keep coming, so the block's
	// queue fills and the request channel stalls.
	task automatic test_backpressure();
		tfg_pkg::req_t f;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_go       <= 1'b1;
		f              = random_req(tfg_pkg::CMD_FILL);
		f.rect_w       = 8'd4;
		f.rect_h       = 8'd4;
		run_request(f, 0);
	endtask

	// Mostly well-formed fills and the odd glyph, with stray ticks and
	// rejected starts mixed in.
	task automatic test_random_requests(input int send_pct, input int recv_pct);
		int stop_at;
		int pick;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		stop_at        = items_sent + PHASE_ITEMS;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 6)
				send_item(random_tick());
			else if (pick < 9)
				run_request(random_req(tfg_pkg::CMD_GLYPH), 3);
			else
				run_request(random_fill(), 8);
		end
	endtask

	initial begin
		send_idle_pct  = 37;
		recv_stall_pct = 48;
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_ticks();
		test_empty_fills();
		test_small_fills();
		test_busy_rejects();
		test_glyph_draw();
		test_random_requests(37, 48);
		test_random_requests(48, 37);
		test_backpressure();
		test_random_requests(0, 0);

		req_valid <= 1'b0;
		while (due_slots.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// File: tft_window_fill_glyph_sequencer_core.f
design/tfg_pkg.sv
design/tfg_front.sv
design/tfg_queue.sv
design/tfg_back.sv
design/tft_window_fill_glyph_sequencer_core.sv
verif/tft_window_fill_glyph_sequencer_core_tb.sv
